// ----- hw/rtl/uer_pkg.sv -----
// Package for the ultrasonic echo ranger: item structs, register indexes,
// status codes and configuration reset values. No dependencies.
package uer_pkg;

  // One input item: one microsecond tick of the echo line.
  typedef struct packed {
    logic start_req;
    logic echo;
  } in_t;

  // One result item.
  typedef struct packed {
    logic        trigger;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  status;
    logic [15:0] pulse_us;
  } out_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_STUCK_TIMEOUT = 3'd0,
    REG_RISE_TIMEOUT  = 3'd1,
    REG_FALL_TIMEOUT  = 3'd2,
    REG_TRIG_WIDTH    = 3'd3,
    REG_MIN_PULSE     = 3'd4,
    REG_MAX_PULSE     = 3'd5
  } reg_idx_e;

  // Measurement status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_STUCK     = 3'd1,
    ST_NO_ECHO   = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_OUT_RANGE = 3'd4
  } status_e;

  // Current register contents, handed from the register file to the sequencer.
  typedef struct packed {
    logic [15:0] stuck_timeout_us;
    logic [15:0] rise_timeout_us;
    logic [15:0] fall_timeout_us;
    logic [7:0]  trigger_width_us;
    logic [15:0] min_pulse_us;
    logic [15:0] max_pulse_us;
  } cfg_t;

  localparam logic [15:0] STUCK_TIMEOUT_RST = 16'd10000;
  localparam logic [15:0] RISE_TIMEOUT_RST  = 16'd10000;
  localparam logic [15:0] FALL_TIMEOUT_RST  = 16'd25000;
  localparam logic [7:0]  TRIG_WIDTH_RST    = 8'd10;
  localparam logic [15:0] MIN_PULSE_RST     = 16'd116;
  localparam logic [15:0] MAX_PULSE_RST     = 16'd23200;

  // Ticks of trigger low before the trigger pulse.
  localparam logic [2:0] TRIG_LOW_TICKS = 3'd5;

endpackage

// ----- hw/rtl/ultrasonic_echo_ranger.sv -----
// Top level of the ultrasonic echo ranger: input register, phase sequencer,
// configuration registers and result register. Depends on uer_pkg,
// uer_cfg_regs and uer_seq.
//
//   channel  direction  signals                         moves
//   in       in         in_valid_i / in_ready_o         one tick item (start_req, echo)
//   out      out        out_valid_o / out_ready_i       one result item per tick item
//   cfg      in         cfg_valid_i / cfg_ready_o       register index and write data
//
// Each item waits in the input register and is processed when it moves on,
// where the sequencer state and the result register update together; its
// result is then held in the result register. One item per cycle is
// sustained while the output is not stalled, one sequencer step per item.
// Reset clears the valid flags, the phase, the counter and the last good
// width, and loads the register defaults. A stalled output holds its result
// and the input register, and the input stops taking items until it drains.
module ultrasonic_echo_ranger #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  uer_pkg::in_t   in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output uer_pkg::out_t  out_item_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [2:0]     cfg_index_i,
  input  logic [15:0]    cfg_data_i
);
  import uer_pkg::*;

  logic  s1_valid_q;
  in_t   s1_item_q;
  logic  out_valid_q;
  out_t  out_item_q;
  logic  advance;
  cfg_t  cfg;
  out_t  res;

  // The held item moves on when the result register is free or being emptied.
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  // Registers may be written at any time; writes must come only while idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  uer_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  uer_seq #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (s1_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- hw/rtl/uer_cfg_regs.sv -----
// Configuration register file of the ultrasonic echo ranger.
// Depends on uer_pkg for the register indexes and reset values.
module uer_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [2:0]        wr_index_i,
  input  logic [15:0]       wr_data_i,
  output uer_pkg::cfg_t     cfg_o
);
  import uer_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stuck_timeout_us <= STUCK_TIMEOUT_RST;
      cfg_q.rise_timeout_us  <= RISE_TIMEOUT_RST;
      cfg_q.fall_timeout_us  <= FALL_TIMEOUT_RST;
      cfg_q.trigger_width_us <= TRIG_WIDTH_RST;
      cfg_q.min_pulse_us     <= MIN_PULSE_RST;
      cfg_q.max_pulse_us     <= MAX_PULSE_RST;
    end else if (wr_en_i) begin
      case (reg_idx_e'(wr_index_i))
        REG_STUCK_TIMEOUT: cfg_q.stuck_timeout_us <= wr_data_i;
        REG_RISE_TIMEOUT:  cfg_q.rise_timeout_us  <= wr_data_i;
        REG_FALL_TIMEOUT:  cfg_q.fall_timeout_us  <= wr_data_i;
        REG_TRIG_WIDTH:    cfg_q.trigger_width_us <= wr_data_i[7:0];
        REG_MIN_PULSE:     cfg_q.min_pulse_us     <= wr_data_i;
        REG_MAX_PULSE:     cfg_q.max_pulse_us     <= wr_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/uer_seq.sv -----
// Phase sequencer of the ultrasonic echo ranger: phase, tick counter and last
// good width, advanced once per item. Depends on uer_pkg.
module uer_seq #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  uer_pkg::in_t   item_i,
  input  uer_pkg::cfg_t  cfg_i,
  output uer_pkg::out_t  res_o
);
  import uer_pkg::*;

  // Comparisons run at the wider of the counter and the 16-bit registers.
  localparam int CmpW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  typedef enum logic [2:0] {
    PH_IDLE, PH_STUCK, PH_TLOW, PH_THIGH, PH_RISE, PH_HIGH
  } phase_e;

  phase_e                   phase_q, phase_d;
  logic [COUNT_WIDTH-1:0]   count_q, count_d;
  logic [15:0]              last_good_q, last_good_d;

  logic [COUNT_WIDTH-1:0]   count_inc;
  logic                     at_max;
  logic [CmpW-1:0]          cnt_ext, inc_ext, limit;
  logic                     expired;

  // Saturating increment; hitting the counter's ceiling also counts as expiry.
  assign at_max    = (count_q == {COUNT_WIDTH{1'b1}});
  assign count_inc = at_max ? count_q : count_q + COUNT_WIDTH'(1);
  assign inc_ext   = CmpW'(count_inc);
  assign cnt_ext   = CmpW'(count_q);

  always_comb begin
    case (phase_q)
      PH_STUCK: limit = CmpW'(cfg_i.stuck_timeout_us);
      PH_TLOW:  limit = CmpW'(TRIG_LOW_TICKS);
      PH_THIGH: limit = CmpW'(cfg_i.trigger_width_us);
      PH_RISE:  limit = CmpW'(cfg_i.rise_timeout_us);
      PH_HIGH:  limit = CmpW'(cfg_i.fall_timeout_us);
      default:  limit = '1;
    endcase
  end

  assign expired = (inc_ext >= limit) || (count_inc == {COUNT_WIDTH{1'b1}});

  always_comb begin
    phase_d          = phase_q;
    count_d          = count_q;
    last_good_d      = last_good_q;
    res_o.trigger    = 1'b0;
    res_o.busy_res   = 1'b1;
    res_o.done_res   = 1'b0;
    res_o.status     = ST_OK;
    case (phase_q)
      PH_IDLE: begin
        res_o.busy_res = 1'b0;
        if (item_i.start_req) begin
          res_o.busy_res = 1'b1;
          phase_d        = PH_STUCK;
          count_d        = '0;
        end
      end
      PH_STUCK: begin
        if (!item_i.echo) begin
          phase_d = PH_TLOW;
          count_d = '0;
        end else if (expired) begin
          res_o.done_res = 1'b1;
          res_o.status   = ST_STUCK;
          phase_d        = PH_IDLE;
          count_d        = '0;
        end else begin
          count_d = count_inc;
        end
      end
      PH_TLOW: begin
        if (expired) begin
          phase_d = PH_THIGH;
          count_d = '0;
        end else begin
          count_d = count_inc;
        end
      end
      PH_THIGH: begin
        res_o.trigger = 1'b1;
        if (expired) begin
          phase_d = PH_RISE;
          count_d = '0;
        end else begin
          count_d = count_inc;
        end
      end
      PH_RISE: begin
        // The rising tick is already the first echo-high microsecond.
        if (item_i.echo) begin
          phase_d = PH_HIGH;
          count_d = COUNT_WIDTH'(1);
        end else if (expired) begin
          res_o.done_res = 1'b1;
          res_o.status   = ST_NO_ECHO;
          phase_d        = PH_IDLE;
          count_d        = '0;
        end else begin
          count_d = count_inc;
        end
      end
      PH_HIGH: begin
        if (!item_i.echo) begin
          if (cnt_ext >= CmpW'(cfg_i.min_pulse_us) &&
              cnt_ext <= CmpW'(cfg_i.max_pulse_us)) begin
            last_good_d = 16'(count_q);
          end else begin
            res_o.status = ST_OUT_RANGE;
          end
          res_o.done_res = 1'b1;
          phase_d        = PH_IDLE;
          count_d        = '0;
        end else if (expired) begin
          res_o.done_res = 1'b1;
          res_o.status   = ST_TOO_LONG;
          phase_d        = PH_IDLE;
          count_d        = '0;
        end else begin
          count_d = count_inc;
        end
      end
      default: begin
        res_o.busy_res = 1'b0;
        phase_d        = PH_IDLE;
        count_d        = '0;
      end
    endcase
    res_o.pulse_us = last_good_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      count_q     <= '0;
      last_good_q <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      last_good_q <= last_good_d;
    end
  end

endmodule
